// ----- hdl/stack_machine_integer_execute_defines.svh -----
// assertion macros for the stack machine execute block
`ifndef STACK_MACHINE_INTEGER_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_INTEGER_EXECUTE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SMIE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// next-cycle implication
`define SMIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

// ----- hdl/smie_pkg.sv -----
// package with types and opcodes of the stack machine execute block
`default_nettype none
package smie_pkg;
  localparam logic [17:0] OP_NOP   = 18'd0;
  localparam logic [17:0] OP_PUSH  = 18'd1;
  localparam logic [17:0] OP_POP   = 18'd2;
  localparam logic [17:0] OP_LIT64 = 18'd5;
  localparam logic [17:0] OP_LIT32 = 18'd6;
  localparam logic [17:0] OP_ADD   = 18'd16;
  localparam logic [17:0] OP_SUB   = 18'd17;
  localparam logic [17:0] OP_MUL   = 18'd18;
  localparam logic [17:0] OP_DIV   = 18'd19;
  localparam logic [17:0] OP_MOD   = 18'd20;
  localparam logic [17:0] OP_POW   = 18'd21;
  localparam logic [17:0] OP_LT    = 18'd128;
  localparam logic [17:0] OP_LE    = 18'd129;
  localparam logic [17:0] OP_EQ    = 18'd130;
  localparam logic [17:0] OP_GE    = 18'd131;
  localparam logic [17:0] OP_GT    = 18'd132;
  localparam logic [17:0] OP_JMP   = 18'd512;
  localparam logic [17:0] OP_JREL  = 18'd513;
  localparam logic [17:0] OP_JZ    = 18'd516;
  localparam logic [17:0] OP_JNZ   = 18'd517;
  localparam logic [17:0] OP_HALT  = 18'd65536;
  localparam logic [17:0] OP_PRINT = 18'd131072;

  typedef struct packed {
    logic               req_type;
    logic [17:0]        opcode;
    logic [15:0]        pc;
    logic signed [63:0] operand;
    logic signed [63:0] load_value;
  } smie_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic               print_valid;
    logic signed [63:0] print_value;
    logic               stack_fault;
    logic               divide_fault;
  } smie_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_POP1, ST_POP2, ST_MEMRD, ST_EXEC, ST_ITER,
    ST_PUSH, ST_DONE
  } smie_state_e;

  typedef enum logic [2:0] {
    ALU_NONE, ALU_MUL, ALU_DIV, ALU_POW
  } smie_alu_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      load_mem;
    logic      pop_r;
    logic      pop_l;
    logic      mem_rd;
    logic      exec;
    logic      iter_start;
    logic      iter_step;
    logic      push;
    logic      finish;
  } smie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       req_load;
    logic       halted;
    logic       fault;
    logic [1:0] pops;
    logic       pushes;
    logic       mem_read;
    logic       iterative;
    logic       iter_last;
  } smie_sts_t;

  function automatic logic [1:0] op_pops(input logic [17:0] op);
    unique case (op)
      OP_POP, OP_JZ, OP_JNZ, OP_PRINT: op_pops = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW,
      OP_LT, OP_LE, OP_EQ, OP_GE, OP_GT: op_pops = 2'd2;
      default: op_pops = 2'd0;
    endcase
  endfunction

  function automatic logic op_pushes(input logic [17:0] op);
    unique case (op)
      OP_PUSH, OP_LIT32, OP_LIT64, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_POW, OP_LT, OP_LE, OP_EQ, OP_GE, OP_GT: op_pushes = 1'b1;
      default: op_pushes = 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ----- hdl/smie_ctrl.sv -----
// sequencing state machine of the stack machine execute block
`default_nettype none
module smie_ctrl
  import smie_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire smie_sts_t sts_i,
  output smie_cmd_t      cmd_o
);
  smie_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (sts_i.req_load || sts_i.halted || sts_i.fault) state_d = ST_DONE;
        else if (sts_i.pops != 2'd0) state_d = ST_POP1;
        else if (sts_i.mem_read) state_d = ST_MEMRD;
        else state_d = ST_EXEC;
      end
      ST_POP1: state_d = (sts_i.pops == 2'd2) ? ST_POP2 : ST_EXEC;
      ST_POP2: state_d = ST_EXEC;
      ST_MEMRD: state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.iterative) state_d = ST_ITER;
        else if (sts_i.pushes) state_d = ST_PUSH;
        else state_d = ST_DONE;
      end
      ST_ITER: if (sts_i.iter_last) state_d = ST_PUSH;
      ST_PUSH: state_d = ST_DONE;
      ST_DONE: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.load_mem = sts_i.req_load;
        cmd_o.finish = sts_i.req_load || sts_i.halted || sts_i.fault;
        cmd_o.mem_rd = sts_i.mem_read;
      end
      ST_POP1: cmd_o.pop_r = 1'b1;
      ST_POP2: cmd_o.pop_l = 1'b1;
      ST_MEMRD: cmd_o.mem_rd = 1'b1;
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.iter_start = sts_i.iterative;
      end
      ST_ITER: cmd_o.iter_step = 1'b1;
      ST_PUSH: cmd_o.push = 1'b1;
      ST_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/smie_dpath.sv -----
// stack, variable memory and arithmetic of the stack machine execute block
`default_nettype none
module smie_dpath
  import smie_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WORDS  = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire smie_in_t  in_i,
  input  wire smie_cmd_t cmd_i,
  output smie_sts_t      sts_o,
  output smie_out_t      out_o
);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int FW = CW + 1;
  localparam int AW = $clog2(DATA_WORDS);

  logic [63:0] stack_mem [STACK_DEPTH];
  logic [63:0] var_mem [DATA_WORDS];

  smie_in_t    req_q;
  logic [CW-1:0] cnt_q;
  logic        halt_q;
  logic [63:0] r_q, l_q, v_q, rd_q;
  logic [15:0] npc_q;
  logic        pv_q, sf_q, df_q;
  logic [1:0]  pops;
  logic        pushes, fault;
  logic [AW-1:0] waddr;
  // iterative unit
  logic [6:0]  it_q;
  logic [1:0]  ph_q;
  logic [63:0] a_q, b_q, acc_q, rem_q;
  logic        neg_q, mod_q;
  smie_alu_e   alu_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  // 32 by 32 multiplier pair, low 64 bits of a product in three passes
  logic [31:0] mx_a, mx_b, my_a, my_b;
  logic [63:0] prod_x, prod_y, px_q, py_q, sum_x, sum_y;
  logic [63:0] ma, mb, cmp_res, lit32;
  logic        slt_lr, slt_rl;
  logic [15:0] pc4, pcrel, exec_npc;

  assign pops = op_pops(req_q.opcode);
  assign pushes = op_pushes(req_q.opcode);
  assign fault = (FW'(pops) > FW'(cnt_q)) ||
    ((FW'(cnt_q) - FW'(pops) + FW'(pushes)) > FW'(STACK_DEPTH));
  assign waddr = req_q.operand[AW+2:3];

  assign sts_o.req_load = req_q.req_type;
  assign sts_o.halted = halt_q;
  assign sts_o.fault = fault;
  assign sts_o.pops = pops;
  assign sts_o.pushes = pushes;
  assign sts_o.mem_read = (req_q.opcode == OP_PUSH);
  assign sts_o.iterative = (req_q.opcode == OP_MUL) ||
    ((req_q.opcode == OP_DIV || req_q.opcode == OP_MOD) && r_q != '0) ||
    (req_q.opcode == OP_POW && !r_q[63]);
  assign sts_o.iter_last = (alu_q == ALU_DIV) ? (it_q == 7'd0)
                                              : (it_q == 7'd0 && ph_q == 2'd2);

  assign pc4 = req_q.pc + 16'd4;
  assign pcrel = pc4 + req_q.operand[15:0];
  assign slt_lr = $signed(l_q) < $signed(r_q);
  assign slt_rl = $signed(r_q) < $signed(l_q);
  assign lit32 = {{32{req_q.operand[31]}}, req_q.operand[31:0]};
  assign ma = l_q[63] ? -l_q : l_q;
  assign mb = r_q[63] ? -r_q : r_q;
  assign rem_sh = {rem_q[62:0], a_q[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, b_q};

  always_comb begin
    case (ph_q)
      2'd0: begin
        mx_a = acc_q[31:0]; mx_b = a_q[31:0];
        my_a = a_q[31:0]; my_b = a_q[31:0];
      end
      2'd1: begin
        mx_a = acc_q[31:0]; mx_b = a_q[63:32];
        my_a = a_q[31:0]; my_b = a_q[63:32];
      end
      default: begin
        mx_a = acc_q[63:32]; mx_b = a_q[31:0];
        my_a = a_q[63:32]; my_b = a_q[31:0];
      end
    endcase
  end

  assign prod_x = 64'(mx_a) * 64'(mx_b);
  assign prod_y = 64'(my_a) * 64'(my_b);
  assign sum_x = (ph_q == 2'd0) ? prod_x : px_q + {prod_x[31:0], 32'd0};
  assign sum_y = (ph_q == 2'd0) ? prod_y : py_q + {prod_y[31:0], 32'd0};

  always_comb begin
    cmp_res = '0;
    case (req_q.opcode)
      OP_LT: cmp_res[0] = slt_lr;
      OP_LE: cmp_res[0] = !slt_rl;
      OP_EQ: cmp_res[0] = (l_q == r_q);
      OP_GE: cmp_res[0] = !slt_lr;
      OP_GT: cmp_res[0] = slt_rl;
      default: ;
    endcase
  end

  always_comb begin
    case (req_q.opcode)
      OP_PUSH, OP_LIT32, OP_POP: exec_npc = req_q.pc + 16'd8;
      OP_LIT64: exec_npc = req_q.pc + 16'd12;
      OP_JMP: exec_npc = req_q.operand[15:0];
      OP_JREL: exec_npc = pcrel;
      OP_JZ: exec_npc = (r_q == '0) ? pcrel : req_q.pc + 16'd8;
      OP_JNZ: exec_npc = (r_q != '0) ? pcrel : req_q.pc + 16'd8;
      default: exec_npc = pc4;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      halt_q <= 1'b0;
    end else begin
      if (cmd_i.pop_r || cmd_i.pop_l) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.push) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.exec && req_q.opcode == OP_HALT) halt_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mem) var_mem[waddr] <= req_q.load_value;
    if (cmd_i.exec && req_q.opcode == OP_POP) var_mem[waddr] <= r_q;
    if (cmd_i.mem_rd) rd_q <= var_mem[waddr];
    if (cmd_i.push) stack_mem[cnt_q[SW-1:0]] <= v_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_r) r_q <= stack_mem[SW'(cnt_q - CW'(1))];
    if (cmd_i.pop_l) l_q <= stack_mem[SW'(cnt_q - CW'(1))];
    if (cmd_i.capture) begin
      req_q <= in_i;
      npc_q <= in_i.pc;
      pv_q <= 1'b0;
      sf_q <= 1'b0;
      df_q <= 1'b0;
      v_q <= '0;
    end
    if (cmd_i.finish && !req_q.req_type && !halt_q) begin
      sf_q <= 1'b1;
      unique case (req_q.opcode)
        OP_PUSH, OP_LIT32, OP_POP, OP_JZ, OP_JNZ: npc_q <= req_q.pc + 16'd8;
        OP_LIT64: npc_q <= req_q.pc + 16'd12;
        default: npc_q <= pc4;
      endcase
    end
    if (cmd_i.exec) begin
      npc_q <= exec_npc;
      case (req_q.opcode)
        OP_PUSH: v_q <= rd_q;
        OP_LIT64: v_q <= req_q.operand;
        OP_LIT32: v_q <= lit32;
        OP_ADD: v_q <= l_q + r_q;
        OP_SUB: v_q <= l_q - r_q;
        OP_DIV, OP_MOD: if (r_q == '0) begin df_q <= 1'b1; v_q <= '0; end
        OP_POW: if (r_q[63]) v_q <= 64'd1;
        OP_LT, OP_LE, OP_EQ, OP_GE, OP_GT: v_q <= cmp_res;
        OP_PRINT: pv_q <= 1'b1;
        default: ;
      endcase
    end
    if (cmd_i.iter_start) begin
      ph_q <= 2'd0;
      mod_q <= (req_q.opcode == OP_MOD);
      neg_q <= (req_q.opcode == OP_MOD) ? l_q[63] : (l_q[63] ^ r_q[63]);
      case (req_q.opcode)
        OP_MUL: begin
          alu_q <= ALU_MUL;
          it_q <= 7'd0;
          a_q <= l_q;
          acc_q <= r_q;
        end
        OP_POW: begin
          alu_q <= ALU_POW;
          it_q <= 7'd63;
          a_q <= l_q;
          b_q <= r_q;
          acc_q <= 64'd1;
        end
        default: begin
          alu_q <= ALU_DIV;
          it_q <= 7'd63;
          a_q <= ma;
          b_q <= mb;
          rem_q <= '0;
        end
      endcase
    end
    if (cmd_i.iter_step) begin
      if (alu_q != ALU_DIV) begin
        px_q <= sum_x;
        py_q <= sum_y;
        if (ph_q == 2'd2) begin
          ph_q <= 2'd0;
          it_q <= it_q - 7'd1;
          if (alu_q == ALU_MUL) v_q <= sum_x;
          else begin
            if (b_q[0]) acc_q <= sum_x;
            a_q <= sum_y;
            b_q <= {1'b0, b_q[63:1]};
            if (it_q == 7'd0) v_q <= b_q[0] ? sum_x : acc_q;
          end
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end else begin
        it_q <= it_q - 7'd1;
        if (!trial[64]) rem_q <= trial[63:0];
        else rem_q <= rem_sh;
        a_q <= {a_q[62:0], !trial[64]};
        if (it_q == 7'd0) begin
          if (mod_q) v_q <= neg_q ? -(trial[64] ? rem_sh : trial[63:0])
                                  : (trial[64] ? rem_sh : trial[63:0]);
          else v_q <= neg_q ? -{a_q[62:0], !trial[64]} : {a_q[62:0], !trial[64]};
        end
      end
    end
  end

  assign out_o.next_pc = npc_q;
  assign out_o.halted = halt_q;
  assign out_o.print_valid = pv_q;
  assign out_o.print_value = pv_q ? r_q : 64'd0;
  assign out_o.stack_fault = sf_q;
  assign out_o.divide_fault = df_q;
endmodule
`default_nettype wire

// ----- hdl/stack_machine_integer_execute.sv -----
// top level of the stack machine execute block
// Runs one bytecode instruction, or stores one host word into the variable
// memory, per input transfer and returns exactly one result transfer. An item
// is handled alone from acceptance to result. Loads, stack faults and items
// while halted go from decode straight to the result; other instructions
// also pass the pop, memory read, execute and push states that they need.
// Div and mod by a nonzero divisor take 64 restoring divide steps, pow 64
// square-and-multiply steps of three passes each on a 32 by 32 multiplier
// pair, and multiply one such step. The result register holds until taken.
// Operand stack and variable memory have no reset; an unwritten variable reads undefined.
`default_nettype none
module stack_machine_integer_execute
  import smie_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WORDS  = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire smie_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output smie_out_t      out_data_o
);
  smie_cmd_t cmd;
  smie_sts_t sts;

  smie_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  smie_dpath #(.STACK_DEPTH(STACK_DEPTH), .DATA_WORDS(DATA_WORDS)) u_dpath (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .out_o(out_data_o)
  );
endmodule
`default_nettype wire

// ----- hdl/smie_checker.sv -----
// port checker of the stack machine execute block
`default_nettype none
`include "stack_machine_integer_execute_defines.svh"
module smie_checker
  import smie_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire smie_out_t out_data_o
);
  `SMIE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `SMIE_ASSERT_IMPLY(a_no_accept_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `SMIE_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `SMIE_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, out_valid_o && out_data_o.halted, !out_valid_o || out_data_o.halted)
  `SMIE_ASSERT_IMPLY(a_print_clean, clk_i, rst_ni, out_valid_o && out_data_o.stack_fault, !out_data_o.print_valid && !out_data_o.divide_fault)
endmodule
bind stack_machine_integer_execute smie_checker u_smie_checker (.*);
`default_nettype wire
